[rtl/fpa_pkg.sv]
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the binary32 adder pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int          ManW     = 24;              // mantissa with hidden bit
    localparam int          ExtW     = ManW + 3;        // with guard, round, sticky
    localparam int          SumW     = ExtW + 1;        // with carry
    localparam int          LzW      = 5;
    localparam logic [7:0]  ExpMax   = 8'hFF;
    localparam logic [31:0] QnanWord = 32'h7FC0_0000;

    // after unpack and operand swap
    typedef struct packed {
        logic              special;
        logic [31:0]       special_word;
        logic              sign;
        logic              same_sign;
        logic              zero_sign;
        logic [7:0]        exp;
        logic [ManW-1:0]   man_a;
        logic [ManW-1:0]   man_b;
        logic [7:0]        diff;
    } unp_t;

    // after alignment and magnitude add or subtract
    typedef struct packed {
        logic              special;
        logic [31:0]       special_word;
        logic              sign;
        logic              zero_sign;
        logic [7:0]        exp;
        logic [SumW-1:0]   mag;
    } sum_t;

    // after leading-zero count
    typedef struct packed {
        logic              special;
        logic [31:0]       special_word;
        logic              sign;
        logic              zero_sign;
        logic [7:0]        exp;
        logic [SumW-1:0]   mag;
        logic [LzW-1:0]    lz;
    } lzc_t;

endpackage

[rtl/float32_adder_core.sv]
// ----------------------------------------------------------------------------
// float32_adder_core
// Binary32 adder, truncating toward zero, four-stage pipeline.
// ----------------------------------------------------------------------------
// One operand pair enters every cycle while the output is not stalled; each sum
// leaves after passing the four register stages (unpack and swap, align and add,
// leading-zero count, normalize and pack), which all advance together whenever
// the output register is empty or being taken. Any NaN or opposite infinities
// give 0x7FC00000, overflow gives infinity, subnormals are handled in full.
module float32_adder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // sum [31:0]
);

    logic          advance;
    logic          unp_valid, add_valid;
    fpa_pkg::unp_t unp_data;
    fpa_pkg::sum_t add_data;

    // hold every stage while a finished result waits
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    fpa_unpack u_unpack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (s_tvalid),
        .operand_a (s_tdata[31:0]),
        .operand_b (s_tdata[63:32]),
        .out_valid (unp_valid),
        .out_data  (unp_data)
    );

    fpa_addsub u_addsub (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (unp_valid),
        .in_data   (unp_data),
        .out_valid (add_valid),
        .out_data  (add_data)
    );

    fpa_normalize u_normalize (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (add_valid),
        .in_data   (add_data),
        .out_valid (m_tvalid),
        .sum       (m_tdata)
    );

endmodule

[rtl/fpa_unpack.sv]
// ----------------------------------------------------------------------------
// fpa_unpack
// Decode specials, order operands by magnitude, form mantissas and shift amount.
// ----------------------------------------------------------------------------
module fpa_unpack (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               in_valid,
    input  logic [31:0]        operand_a,
    input  logic [31:0]        operand_b,
    output logic               out_valid,
    output fpa_pkg::unp_t      out_data
);

    logic          valid_reg;
    fpa_pkg::unp_t data_reg, data_next;

    always_comb begin
        logic        a_nan, b_nan, a_inf, b_inf, swap;
        logic [31:0] big, lit;
        logic [7:0]  eb, el;
        a_nan = (operand_a[30:23] == fpa_pkg::ExpMax) && (operand_a[22:0] != '0);
        b_nan = (operand_b[30:23] == fpa_pkg::ExpMax) && (operand_b[22:0] != '0);
        a_inf = (operand_a[30:23] == fpa_pkg::ExpMax) && (operand_a[22:0] == '0);
        b_inf = (operand_b[30:23] == fpa_pkg::ExpMax) && (operand_b[22:0] == '0);
        swap  = operand_b[30:0] > operand_a[30:0];
        big   = swap ? operand_b : operand_a;
        lit   = swap ? operand_a : operand_b;
        eb    = (big[30:23] == '0) ? 8'd1 : big[30:23];
        el    = (lit[30:23] == '0) ? 8'd1 : lit[30:23];

        data_next.special      = a_nan || b_nan || a_inf || b_inf;
        priority if (a_nan || b_nan) begin
            data_next.special_word = fpa_pkg::QnanWord;
        end else if (a_inf && b_inf) begin
            data_next.special_word = (operand_a[31] == operand_b[31]) ? operand_a
                                                                      : fpa_pkg::QnanWord;
        end else if (a_inf) begin
            data_next.special_word = operand_a;
        end else begin
            data_next.special_word = operand_b;
        end
        data_next.sign      = big[31];
        data_next.same_sign = (operand_a[31] == operand_b[31]);
        data_next.zero_sign = operand_a[31] & operand_b[31];
        data_next.exp       = eb;
        data_next.man_a     = {(big[30:23] != '0), big[22:0]};
        data_next.man_b     = {(lit[30:23] != '0), lit[22:0]};
        data_next.diff      = eb - el;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/fpa_addsub.sv]
// ----------------------------------------------------------------------------
// fpa_addsub
// Align the smaller operand with guard, round and sticky, then add or subtract.
// ----------------------------------------------------------------------------
module fpa_addsub (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               in_valid,
    input  fpa_pkg::unp_t      in_data,
    output logic               out_valid,
    output fpa_pkg::sum_t      out_data
);

    logic          valid_reg;
    fpa_pkg::sum_t data_reg, data_next;

    always_comb begin
        logic [fpa_pkg::ExtW-1:0] ma, mb, bb, lost_mask;
        logic                     sticky;
        ma        = {in_data.man_a, 3'b000};
        mb        = {in_data.man_b, 3'b000};
        lost_mask = '0;
        if (in_data.diff >= 8'(fpa_pkg::ExtW)) begin
            bb     = '0;
            sticky = (mb != '0);
        end else begin
            bb        = mb >> in_data.diff[4:0];
            lost_mask = ~({fpa_pkg::ExtW{1'b1}} << in_data.diff[4:0]);
            sticky    = ((mb & lost_mask) != '0);
        end
        // subtracting the sticky bit keeps the difference truncated toward zero
        if (in_data.same_sign) begin
            data_next.mag = {1'b0, ma} + {1'b0, bb};
        end else begin
            data_next.mag = {1'b0, ma} - {1'b0, bb} - fpa_pkg::SumW'(sticky);
        end
        data_next.special      = in_data.special;
        data_next.special_word = in_data.special_word;
        data_next.sign         = in_data.sign;
        data_next.zero_sign    = in_data.zero_sign;
        data_next.exp          = in_data.exp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/fpa_normalize.sv]
// ----------------------------------------------------------------------------
// fpa_normalize
// Count leading zeros, then shift, clamp to subnormal range, saturate and pack.
// ----------------------------------------------------------------------------
module fpa_normalize (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               in_valid,
    input  fpa_pkg::sum_t      in_data,
    output logic               out_valid,
    output logic [31:0]        sum
);

    logic          lzc_valid_reg;
    fpa_pkg::lzc_t lzc_reg, lzc_next;
    logic          out_valid_reg;
    logic [31:0]   sum_reg, sum_next;

    always_comb begin
        logic [fpa_pkg::LzW-1:0] idx;
        idx = '0;
        for (int i = 0; i < fpa_pkg::SumW; i++) begin
            if (in_data.mag[i]) begin
                idx = fpa_pkg::LzW'(i);
            end
        end
        lzc_next.special      = in_data.special;
        lzc_next.special_word = in_data.special_word;
        lzc_next.sign         = in_data.sign;
        lzc_next.zero_sign    = in_data.zero_sign;
        lzc_next.exp          = in_data.exp;
        lzc_next.mag          = in_data.mag;
        lzc_next.lz           = fpa_pkg::LzW'(fpa_pkg::SumW - 1) - idx;
    end

    always_comb begin
        logic [fpa_pkg::LzW-1:0]  shamt;
        logic [fpa_pkg::SumW-1:0] shifted;
        logic [8:0]               exp_res;
        logic                     subnorm;
        subnorm = {3'b000, lzc_reg.lz} > lzc_reg.exp;
        // below the normal range the shift stops at the minimum exponent
        shamt   = subnorm ? lzc_reg.exp[fpa_pkg::LzW-1:0] : lzc_reg.lz;
        shifted = lzc_reg.mag << shamt;
        exp_res = {1'b0, lzc_reg.exp} + 9'd1 - {4'b0000, lzc_reg.lz};
        priority if (lzc_reg.special) begin
            sum_next = lzc_reg.special_word;
        end else if (lzc_reg.mag == '0) begin
            sum_next = {lzc_reg.zero_sign, 31'b0};
        end else if (subnorm) begin
            sum_next = {lzc_reg.sign, 8'h00, shifted[26:4]};
        end else if (exp_res >= {1'b0, fpa_pkg::ExpMax}) begin
            sum_next = {lzc_reg.sign, fpa_pkg::ExpMax, 23'b0};
        end else begin
            sum_next = {lzc_reg.sign, exp_res[7:0], shifted[26:4]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lzc_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            lzc_valid_reg <= in_valid;
            out_valid_reg <= lzc_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            lzc_reg <= lzc_next;
            sum_reg <= sum_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sum       = sum_reg;

endmodule

[rtl/fpa_checker.sv]
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks for the binary32 adder, bound to the top level.
// ----------------------------------------------------------------------------
module fpa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // the pipeline takes input exactly when its output can move
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // every NaN leaving the block is the canonical quiet NaN
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[30:23] == 8'hFF) && (m_tdata[22:0] != 23'd0)
            |-> m_tdata == 32'h7FC0_0000)
        else $error("non-canonical NaN");

    // reset empties the pipeline
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind float32_adder_core fpa_checker u_fpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
